[rtl/assert_macros.svh]
// Assertion helpers shared by checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/gtg_pkg.sv]
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared constants and the arctangent table of the go-to-goal controller.
// ----------------------------------------------------------------------------
`default_nettype none
package gtg_pkg;
  localparam int GTG_CORDIC_STEPS = 16;
  localparam int GTG_MAX_STEPS = 32;
  localparam int ANG_W = 36;      // Q2.30 angles with headroom
  localparam int VEC_W = 40;      // CORDIC x/y datapath
  localparam logic signed [ANG_W-1:0] ANG_PI = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 36'sd6746518852;
  localparam logic [29:0] GAIN_INV = 30'd652032874;

  localparam logic [2:0] REG_GOAL_X = 3'd0;
  localparam logic [2:0] REG_GOAL_Y = 3'd1;
  localparam logic [2:0] REG_TOL    = 3'd2;
  localparam logic [2:0] REG_SGAIN  = 3'd3;
  localparam logic [2:0] REG_TGAIN  = 3'd4;

  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd843314856;  5'd1: v = 30'd497837829;
      5'd2: v = 30'd263043836;  5'd3: v = 30'd133525158;
      5'd4: v = 30'd67021687;   5'd5: v = 30'd33543515;
      5'd6: v = 30'd16775850;   5'd7: v = 30'd8388437;
      5'd8: v = 30'd4194282;    5'd9: v = 30'd2097149;
      5'd10: v = 30'd1048575;   5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;    5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;     5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;     5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;      5'd21: v = 30'd511;
      5'd22: v = 30'd255;       5'd23: v = 30'd127;
      5'd24: v = 30'd63;        5'd25: v = 30'd31;
      5'd26: v = 30'd15;        5'd27: v = 30'd7;
      5'd28: v = 30'd3;         5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[rtl/gtg_cordic.sv]
// ----------------------------------------------------------------------------
// gtg_cordic
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gtg_cordic import gtg_pkg::*; #(
  parameter int STEPS = GTG_CORDIC_STEPS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [VEC_W-1:0] x_in,
  input  wire logic signed [VEC_W-1:0] y_in,
  output logic                         done,
  output logic signed [ANG_W-1:0]      angle,
  output logic signed [VEC_W-1:0]      x_out
);
  localparam int CW = $clog2(STEPS + 1);
  logic signed [VEC_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;
  logic [CW-1:0] cnt_r;
  logic busy_r, done_r;
  logic [4:0] sh;
  logic signed [VEC_W-1:0] xs, ys;
  logic signed [ANG_W-1:0] at;

  assign sh = 5'(cnt_r);
  assign xs = x_r >>> sh;
  assign ys = y_r >>> sh;
  assign at = ANG_W'($signed({1'b0, atan_lut(sh)}));

  always_comb begin
    if (!y_r[VEC_W-1]) begin
      x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      // zero vector finishes at once; otherwise after the last step
      done_r <= (start && x_in == '0 && y_in == '0) ||
                (!start && busy_r && cnt_r == CW'(STEPS - 1));
      if (start) begin
        cnt_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          x_r <= '0; y_r <= '0; z_r <= '0; busy_r <= 1'b0;
        end else if (x_in[VEC_W-1]) begin
          busy_r <= 1'b1;
          x_r <= -x_in; y_r <= -y_in;
          z_r <= y_in[VEC_W-1] ? -ANG_PI : ANG_PI;
        end else begin
          busy_r <= 1'b1;
          x_r <= x_in; y_r <= y_in; z_r <= '0;
        end
      end else if (busy_r) begin
        x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign angle = z_r;
  assign x_out = x_r;
endmodule
`default_nettype wire

[rtl/go_to_goal_p_controller_core.sv]
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_core
// Proportional go-to-goal controller on odometry samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one odometry request (position, quaternion z/w), valid/stall.
//   out_* : one or two command results per request, valid/stall.
//   cfg_* : register writes (goal, tolerance, gains), index/data, valid/ready.
// Steps: two vectoring passes in turn on the shared iterative CORDIC,
//   a bit-serial gain correction of the magnitude, then both gain
//   products side by side. A zero offset or zero quaternion skips the
//   CORDIC iterations.
// Requests are taken one at a time: a new one is held off until the
//   results of the last are taken. After arrival a request goes
//   straight to the stop state, which then registers the stop result.
// Reset clears the arrived flag and loads register defaults.
// A stalled result holds until taken; in_stall stays high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module go_to_goal_p_controller_core import gtg_pkg::*; #(
  parameter int CORDIC_STEPS = GTG_CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_robot_x,
  input  wire logic signed [31:0] in_robot_y,
  input  wire logic signed [15:0] in_quat_z,
  input  wire logic signed [15:0] in_quat_w,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_linear_speed,
  output logic signed [31:0]      out_angular_rate,
  output logic                    out_arrived,
  output logic                    out_last_of_run,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_POS_W, S_MAG, S_QUAT, S_QUAT_W, S_ERR, S_MUL, S_OUT, S_STOP
  } state_t;

  state_t state_r;
  logic signed [31:0] goal_x_r, goal_y_r;
  logic [30:0] tol_r;
  logic [15:0] sgain_r, tgain_r;
  logic arrived_r;
  logic signed [31:0] rx_r, ry_r;
  logic signed [15:0] qz_r, qw_r;
  logic signed [ANG_W-1:0] bearing_r, err_r;
  logic [VEC_W-1:0] magx_r;
  logic [33:0] dist_r;
  // bit-serial multiplier: acc += (mcand << k) when multiplier bit k set
  logic [4:0] bit_r;
  logic [63:0] mag_acc_r;
  logic [71:0] sp_acc_r;
  logic signed [71:0] rt_acc_r;
  logic [1:0] mphase_r;
  logic near_r;
  logic signed [31:0] spd_r, rate_r;

  logic cs_start, cs_done;
  logic signed [VEC_W-1:0] cs_x, cs_y, cs_xo;
  logic signed [ANG_W-1:0] cs_ang;

  gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cs_start), .x_in(cs_x), .y_in(cs_y),
    .done(cs_done), .angle(cs_ang), .x_out(cs_xo)
  );

  always_comb begin
    cs_start = (state_r == S_POS) || (state_r == S_QUAT);
    if (state_r == S_POS) begin
      cs_x = VEC_W'(goal_x_r) - VEC_W'(rx_r);
      cs_y = VEC_W'(goal_y_r) - VEC_W'(ry_r);
    end else begin
      cs_x = VEC_W'($signed({qw_r, 16'd0}));
      cs_y = VEC_W'($signed({qz_r, 16'd0}));
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != S_IDLE);

  logic signed [ANG_W-1:0] e0, e1, e2;
  logic [71:0] sp_r2;
  logic signed [71:0] rt_r2;
  always_comb begin
    e0 = bearing_r - (cs_ang <<< 1);
    // error can reach nearly three half-turns either way: up to two folds
    e1 = e0;
    if (e0 >= ANG_PI) e1 = e0 - ANG_TWO_PI;
    else if (e0 < -ANG_PI) e1 = e0 + ANG_TWO_PI;
    e2 = e1;
    if (e1 >= ANG_PI) e2 = e1 - ANG_TWO_PI;
    else if (e1 < -ANG_PI) e2 = e1 + ANG_TWO_PI;
    sp_r2 = sp_acc_r + 72'd128;
    rt_r2 = rt_acc_r + 72'sd2097152;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; arrived_r <= 1'b0; out_valid <= 1'b0;
      goal_x_r <= '0; goal_y_r <= '0; tol_r <= 31'd6554;
      sgain_r <= 16'd256; tgain_r <= 16'd256;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GOAL_X: goal_x_r <= cfg_data;
          REG_GOAL_Y: goal_y_r <= cfg_data;
          REG_TOL:    tol_r <= cfg_data[30:0];
          REG_SGAIN:  sgain_r <= cfg_data[15:0];
          REG_TGAIN:  tgain_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          rx_r <= in_robot_x; ry_r <= in_robot_y;
          qz_r <= in_quat_z; qw_r <= in_quat_w;
          state_r <= arrived_r ? S_STOP : S_POS;
        end
        S_POS: state_r <= S_POS_W;
        S_POS_W: if (cs_done) begin
          bearing_r <= cs_ang;
          magx_r <= cs_xo[VEC_W-1] ? '0 : cs_xo;
          mag_acc_r <= '0; bit_r <= '0; state_r <= S_MAG;
        end
        S_MAG: begin
          // 30 multiplier bits, one per cycle
          if (GAIN_INV[bit_r]) mag_acc_r <= mag_acc_r + (64'(magx_r) << bit_r);
          if (bit_r == 5'd29) state_r <= S_QUAT;
          bit_r <= bit_r + 1'b1;
        end
        S_QUAT: begin
          dist_r <= 34'((mag_acc_r + 64'd536870912) >> 30);
          state_r <= S_QUAT_W;
        end
        S_QUAT_W: if (cs_done) begin
          err_r <= e2; state_r <= S_MUL; bit_r <= '0;
          sp_acc_r <= '0; rt_acc_r <= '0;
          near_r <= ({1'b0, dist_r} <= {4'd0, tol_r});
        end
        S_ERR: state_r <= S_MUL;
        S_MUL: begin
          if (sgain_r[bit_r[3:0]]) sp_acc_r <= sp_acc_r + (72'(dist_r) << bit_r[3:0]);
          if (tgain_r[bit_r[3:0]])
            rt_acc_r <= rt_acc_r + (72'(err_r) <<< bit_r[3:0]);
          if (bit_r == 5'd15) state_r <= S_OUT;
          bit_r <= bit_r + 1'b1;
        end
        S_OUT: begin
          if (!out_valid) begin
            spd_r <= ((sp_r2 >> 8) > 72'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(sp_r2 >> 8);
            if ((rt_r2 >>> 22) > 72'sh7FFFFFFF) rate_r <= 32'sh7FFFFFFF;
            else if ((rt_r2 >>> 22) < -72'sh80000000) rate_r <= 32'sh80000000;
            else rate_r <= 32'(rt_r2 >>> 22);
            out_arrived <= 1'b0; out_last_of_run <= !near_r;
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (near_r) begin
              arrived_r <= 1'b1; state_r <= S_STOP;
            end else state_r <= S_IDLE;
          end
        end
        S_STOP: begin
          if (!out_valid) begin
            spd_r <= '0; rate_r <= '0; out_arrived <= 1'b1; out_last_of_run <= 1'b1;
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_linear_speed = spd_r;
  assign out_angular_rate = rate_r;
endmodule
`default_nettype wire

[rtl/gtg_checker.sv]
// ----------------------------------------------------------------------------
// gtg_checker
// Port-level checks on the go-to-goal controller.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module gtg_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_arrived,
  input wire logic out_last_of_run,
  input wire logic signed [31:0] out_linear_speed
);
  `ASSERT_IMPL(a_stop_last, clk, rst_n, out_valid && out_arrived, out_last_of_run, "stop not last")
  `ASSERT_IMPL(a_stop_zero, clk, rst_n, out_valid && out_arrived, out_linear_speed == 0, "stop moves")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `ASSERT_IMPL(a_busy, clk, rst_n, out_valid, in_stall, "request taken with result pending")
  `ASSERT_NEXT(a_take, clk, rst_n, in_valid && !in_stall, in_stall, "request not held off")
endmodule

bind go_to_goal_p_controller_core gtg_checker u_gtg_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_arrived(out_arrived),
  .out_last_of_run(out_last_of_run), .out_linear_speed(out_linear_speed)
);
`default_nettype wire

[sim/gtg_monitor.sv]
// ----------------------------------------------------------------------------
// gtg_monitor
// Watches the request, result and register ports of the go-to-goal
// controller, predicts the command results of each request and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module gtg_monitor import gtg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [31:0] in_robot_x,
  input  wire logic signed [31:0] in_robot_y,
  input  wire logic signed [15:0] in_quat_z,
  input  wire logic signed [15:0] in_quat_w,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] out_linear_speed,
  input  wire logic signed [31:0] out_angular_rate,
  input  wire logic               out_arrived,
  input  wire logic               out_last_of_run,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      pending,
  output int                      errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = GTG_CORDIC_STEPS;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint unsigned INV_GAIN = 64'd652032874;

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [31:0] rate;
    logic               arrived;
    logic               last;
  } cmd_t;

  cmd_t cmd_q[$];

  logic signed [31:0] goal_x, goal_y;
  logic [30:0]        tol;
  logic [15:0]        speed_gain, turn_gain;
  logic               at_goal;

  // angle of (x, y) in Q2.30 and gain-corrected magnitude
  function automatic longint bearing_of(input longint x0, input longint y0,
                                        output longint unsigned mag);
    longint x, y, z, xs, ys;
    longint unsigned ux;
    x = x0;
    y = y0;
    z = 0;
    mag = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> (i & 31);
      ys = y >>> (i & 31);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_lut(5'(i)));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_lut(5'(i)));
      end
    end
    ux = (x > 0) ? longint'(x) : 0;
    mag = (ux * INV_GAIN + (64'd1 << 29)) >> 30;
    return z;
  endfunction

  task automatic predict_commands();
    longint dx, dy, brg, hdg, err, rate;
    longint unsigned gap, dummy, sp;
    cmd_t c;
    if (at_goal) begin
      c = '{speed: 0, rate: 0, arrived: 1'b1, last: 1'b1};
      cmd_q.push_back(c);
      return;
    end
    dx = longint'(goal_x) - longint'(in_robot_x);
    dy = longint'(goal_y) - longint'(in_robot_y);
    brg = bearing_of(dx, dy, gap);
    hdg = 2 * bearing_of(longint'(in_quat_w) * 65536, longint'(in_quat_z) * 65536, dummy);
    err = brg - hdg;
    while (err >= PI_Q30) err -= TWO_PI_Q30;
    while (err < -PI_Q30) err += TWO_PI_Q30;
    sp = (longint'(speed_gain) * gap + 128) >> 8;
    rate = (longint'(turn_gain) * err + (64'sd1 << 21)) >>> 22;
    if (rate > 64'sd2147483647) rate = 64'sd2147483647;
    if (rate < -64'sd2147483648) rate = -64'sd2147483648;
    c.speed = (sp > 64'd2147483647) ? 32'sh7fffffff : sp[31:0];
    c.rate = rate[31:0];
    c.arrived = 1'b0;
    c.last = !(gap <= longint'(tol));
    cmd_q.push_back(c);
    if (gap <= longint'(tol)) begin
      c = '{speed: 0, rate: 0, arrived: 1'b1, last: 1'b1};
      cmd_q.push_back(c);
      at_goal = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    cmd_t exp_c;
    if (!rst_n) begin
      goal_x = 0;
      goal_y = 0;
      tol = 31'd6554;
      speed_gain = 16'd256;
      turn_gain = 16'd256;
      at_goal = 1'b0;
      cmd_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GOAL_X: goal_x = cfg_data;
          REG_GOAL_Y: goal_y = cfg_data;
          REG_TOL:    tol = cfg_data[30:0];
          REG_SGAIN:  speed_gain = cfg_data[15:0];
          REG_TGAIN:  turn_gain = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_commands();
      if (out_valid && !out_stall) begin
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected result speed=%0d rate=%0d arrived=%0b last=%0b",
                   $time, out_linear_speed, out_angular_rate, out_arrived,
                   out_last_of_run);
          errors <= errors + 1;
        end else begin
          exp_c = cmd_q.pop_front();
          if (exp_c.speed !== out_linear_speed || exp_c.rate !== out_angular_rate ||
              exp_c.arrived !== out_arrived || exp_c.last !== out_last_of_run) begin
            $display("%0t: mismatch expected speed=%0d rate=%0d arrived=%0b last=%0b",
                     $time, exp_c.speed, exp_c.rate, exp_c.arrived, exp_c.last);
            $display("%0t:          actual   speed=%0d rate=%0d arrived=%0b last=%0b",
                     $time, out_linear_speed, out_angular_rate, out_arrived,
                     out_last_of_run);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= cmd_q.size();
  end
endmodule
`default_nettype wire

[sim/tb_go_to_goal_p_controller_core.sv]
// ----------------------------------------------------------------------------
// tb_go_to_goal_p_controller_core
// Drives odometry requests and register writes into the controller under
// varying idle and stall patterns; the monitor predicts and checks results.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_go_to_goal_p_controller_core import gtg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic signed [31:0] in_robot_x = '0, in_robot_y = '0;
  logic signed [15:0] in_quat_z = '0, in_quat_w = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [31:0] out_linear_speed, out_angular_rate;
  logic out_arrived, out_last_of_run;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int pending, errors;

  int tx_pct = 0, rx_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  longint cycles = 0;
  longint gx = 0, gy = 0, tol_now = 6554;

  always #5 clk = ~clk;

  go_to_goal_p_controller_core dut (.*);
  gtg_monitor mon (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left = 400;
    if (hold_left > 1) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (hold_left == 1) hold_left = -1;
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  task automatic send(input logic [31:0] x, input logic [31:0] y,
                      input logic [15:0] qz, input logic [15:0] qw);
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_pct);
    end
    in_valid <= 1'b1;
    in_robot_x <= x;
    in_robot_y <= y;
    in_quat_z <= qz;
    in_quat_w <= qw;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GOAL_X: gx = longint'(signed'(val));
      REG_GOAL_Y: gy = longint'(signed'(val));
      REG_TOL:    tol_now = val[30:0];
      default: ;
    endcase
  endtask

  // random request kept clear of the arrival circle
  task automatic send_random();
    longint x, y, lim;
    logic [15:0] qz, qw;
    lim = 2 * tol_now + 4096;
    do begin
      if ($urandom_range(3) == 0) begin
        x = signed'($urandom);
        y = signed'($urandom);
      end else begin
        x = gx - $signed($urandom_range(8388608)) + 4194304;
        y = gy - $signed($urandom_range(8388608)) + 4194304;
        if (x > 64'sd2147483647 || x < -64'sd2147483648) x = signed'($urandom);
        if (y > 64'sd2147483647 || y < -64'sd2147483648) y = signed'($urandom);
      end
    end while ((gx - x < lim && x - gx < lim) && (gy - y < lim && y - gy < lim));
    if ($urandom_range(9) == 0) begin
      qz = 16'($urandom);
      qw = 16'($urandom);
    end else begin
      qz = 16'($urandom_range(32768) - 16384);
      qw = 16'($urandom_range(32768) - 16384);
    end
    send(x[31:0], y[31:0], qz, qw);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, pre-rotation cases, quaternion corners
    send(32'h8000_0000, 32'h8000_0000, 16'sd0, 16'sd0);
    send(32'h7fff_ffff, 32'h7fff_ffff, 16'sd16384, 16'sd0);
    send(32'h7fff_ffff, 32'h0000_0000, -16'sd16384, 16'sd0);
    send(32'h7fff_ffff, 32'h0001_0000, 16'sd0, -16'sd16384);
    send(32'h0010_0000, 32'h8000_0000, 16'sd16384, -16'sd16384);
    send(32'h0000_0000, 32'h7fff_ffff, -16'sd16384, -16'sd16384);
    send(32'h8000_0000, 32'h7fff_ffff, 16'sh7fff, 16'sh8000);
    send(32'h0000_0000, 32'h8000_0000, 16'sh8000, 16'sh7fff);
    send(32'hffff_0000, 32'h0000_0000, 16'sd16384, 16'sd16384);
    drain();
    write_reg(REG_SGAIN, 32'h0000_ffff);
    write_reg(REG_TGAIN, 32'h0000_ffff);
    write_reg(REG_UNUSED, 32'hffff_ffff);
    send(32'h8000_0000, 32'h8000_0000, 16'sd11585, -16'sd11585);
    send(32'h7fff_ffff, 32'h8000_0000, -16'sd11585, 16'sd11585);
    send(32'h0002_0000, 32'hfffe_0000, 16'sd0, 16'sd0);
    drain();
    write_reg(REG_GOAL_X, 32'h8000_0000);
    write_reg(REG_GOAL_Y, 32'h7fff_ffff);
    write_reg(REG_TOL, 32'h0000_0000);
    write_reg(REG_SGAIN, 32'h0000_0000);
    write_reg(REG_TGAIN, 32'h0000_0000);
    send(32'h7fff_ffff, 32'h8000_0000, 16'sd16384, 16'sd0);
    send(32'h8000_0001, 32'h7fff_ffff, 16'sd0, 16'sd16384);
    drain();
    write_reg(REG_TGAIN, 32'h0000_0100);

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_GOAL_X, (p % 3 == 0) ? $urandom : ($urandom_range(2000000) << 8));
      write_reg(REG_GOAL_Y, (p % 3 == 0) ? $urandom : -($urandom_range(2000000) << 8));
      write_reg(REG_TOL, (p == 1) ? 32'd0 : (p == 5) ? 32'd524288 : $urandom_range(524288));
      write_reg(REG_SGAIN, (p == 2) ? 32'h0000_ffff : $urandom_range(65535));
      write_reg(REG_TGAIN, (p == 6) ? 32'h0000_ffff : $urandom_range(65535));
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 73; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 73; end
        default: begin tx_pct = 7; rx_pct = 7; end
      endcase
      for (int n = 0; n < 235; n++) begin
        if (p == 4 && n == 10) hold_req <= 1'b1;
        if (n == 120) drain();
        send_random();
      end
      drain();
    end

    // arrival: zero offset with zero tolerance, then stop commands only
    tx_pct = 7;
    rx_pct = 30;
    write_reg(REG_GOAL_X, 32'h0001_0000);
    write_reg(REG_GOAL_Y, 32'hffff_0000);
    write_reg(REG_TOL, 32'd0);
    send(32'h0001_0000, 32'hffff_0000, 16'sd5000, 16'sd14000);
    send(32'h7fff_ffff, 32'h8000_0000, 16'sd0, 16'sd0);
    drain();
    write_reg(REG_TOL, 32'h7fff_ffff);
    write_reg(REG_GOAL_X, 32'h7fff_ffff);
    send(32'h8000_0000, 32'h8000_0000, 16'sh8000, 16'sh7fff);
    send(32'h1234_5678, 32'h0000_0000, 16'sd16384, 16'sd0);
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
